// ----- hw/rtl/gh_pkg.sv -----
// gh_pkg: shared constants and the base32 alphabet lookup for the geohash encoder
// no dependencies; used by gh_cell and geohash_encoder_top
`timescale 1ns / 1ps

package gh_pkg;

    // field widths fixed by the interface
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned SYM_W    = 5;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned POS_W    = 4;

    // full span of each axis in 1e-7 degree units (twice the bound)
    localparam logic [31:0] LAT_DIV  = 32'd1800000000;
    localparam logic [31:0] LON_DIV  = 32'd3600000000;

    // length register value after reset
    localparam logic [3:0]  LEN_RESET = 4'd12;

    // ascii code for a symbol of "0123456789bcdefghjkmnpqrstuvwxyz"
    function automatic logic [6:0] sym_to_char(input logic [4:0] sym);
        logic [6:0] s;
        s = {2'b00, sym};
        if (sym < 5'd10) begin
            sym_to_char = s + 7'd48;
        end else if (sym <= 5'd16) begin
            sym_to_char = s + 7'd88;
        end else if (sym <= 5'd18) begin
            sym_to_char = s + 7'd89;
        end else if (sym <= 5'd20) begin
            sym_to_char = s + 7'd90;
        end else begin
            sym_to_char = s + 7'd91;
        end
    endfunction

endpackage

// ----- hw/rtl/gh_cell.sv -----
// gh_cell: three-stage quantizer of one axis to a cell number of BITS bits
// exact floor((v + DIV/2) * 2^BITS / DIV) by reciprocal multiply and one correction
// depends on gh_pkg
`timescale 1ns / 1ps

module gh_cell #(
    parameter int unsigned BITS = 30,
    parameter logic [31:0] DIV  = 32'd3600000000
) (
    input  logic                             aclk,
    input  logic                             adv,
    input  logic signed [gh_pkg::COORD_W-1:0] coord,
    output logic [BITS-1:0]                  cell_num
);

    localparam logic [33:0] BOUND    = {2'b00, DIV >> 1};
    localparam logic [63:0] RECIP_64 = (64'd1 << (BITS + 32)) / {32'd0, DIV};
    localparam logic [31:0] RECIP    = RECIP_64[31:0];

    // offset and range checks
    logic signed [33:0] sum;
    logic [31:0]        x_reg, x_next;
    logic               hi_reg, hi_next, lo_reg, lo_next;

    assign sum = $signed({{2{coord[31]}}, coord}) + $signed(BOUND);

    always_comb begin
        x_next  = sum[31:0];
        hi_next = (sum >= $signed({1'b0, DIV, 1'b0} >> 1));
        lo_next = sum[33] || (sum == 34'sd0);
    end

    // stage 2: reciprocal product
    logic [63:0] prod_reg, prod_next;
    logic [31:0] x2_reg;
    logic        hi2_reg, lo2_reg;

    assign prod_next = {32'd0, x_reg} * {32'd0, RECIP};

    // stage 3: back-multiply of the estimate
    logic [BITS-1:0] q0;
    logic [BITS-1:0] q0_reg;
    logic [63:0]     qd_reg, qd_next;
    logic [31:0]     x3_reg;
    logic            hi3_reg, lo3_reg;

    assign q0      = prod_reg[32 +: BITS];
    assign qd_next = 64'(q0) * {32'd0, DIV};

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            prod_reg <= prod_next;
            x2_reg   <= x_reg;
            hi2_reg  <= hi_reg;
            lo2_reg  <= lo_reg;
            q0_reg   <= q0;
            qd_reg   <= qd_next;
            x3_reg   <= x2_reg;
            hi3_reg  <= hi2_reg;
            lo3_reg  <= lo2_reg;
        end
    end

    // remainder check lifts the estimate by one where needed, then saturation
    logic [63:0] rem;

    always_comb begin
        rem = ({32'd0, x3_reg} << BITS) - qd_reg;
        if (hi3_reg) begin
            cell_num = '1;
        end else if (lo3_reg) begin
            cell_num = '0;
        end else if (rem >= {32'd0, DIV}) begin
            cell_num = q0_reg + BITS'(1);
        end else begin
            cell_num = q0_reg;
        end
    end

endmodule

// ----- hw/rtl/geohash_encoder_top.sv -----
// geohash_encoder_top: geohash base32 encoder, one character per result request
// depends on gh_pkg and gh_cell
`timescale 1ns / 1ps

// path: input register, gh_cell stages, serializer output register; any of these can stall
// throughput: the serializer sends one symbol per cycle while m_ready is high, the effective
//   hash length (0 to MAX_CHARS) per coordinate, and loads the next as the last symbol is taken
// a zero length consumes the coordinate and produces nothing
// reset: pipeline and output empty, hash length register set to 12

module geohash_encoder_top #(
    parameter int unsigned MAX_CHARS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gh_pkg::LEN_W-1:0]            cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gh_pkg::COORD_W-1:0]   s_lat_e7,
    input  logic signed [gh_pkg::COORD_W-1:0]   s_lon_e7,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gh_pkg::CHAR_W-1:0]           m_symbol_char,
    output logic [gh_pkg::SYM_W-1:0]            m_symbol_value,
    output logic [gh_pkg::POS_W-1:0]            m_position,
    output logic                                m_last
);

    localparam int unsigned TOTAL = 5 * MAX_CHARS;
    localparam int unsigned LON_N = (TOTAL + 1) / 2;
    localparam int unsigned LAT_N = TOTAL / 2;
    localparam logic [3:0]  MAX_LEN = 4'(MAX_CHARS);

    // hash length register
    logic [3:0] len_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= gh_pkg::LEN_RESET;
        end else if (cfg_wr_en) begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    logic [3:0] len_eff;
    assign len_eff = (len_cfg_reg > MAX_LEN) ? MAX_LEN : len_cfg_reg;

    // pipeline advance: stalls only when the last stage holds an item the serializer cannot take
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ser_free, adv;
    logic m_valid_reg, m_valid_next;
    logic last_cur;

    assign ser_free = !m_valid_reg || (m_ready && last_cur);
    assign adv      = !v4_reg || ser_free;
    assign s_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // input register
    logic signed [31:0] lat_reg, lon_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_reg <= s_lat_e7;
            lon_reg <= s_lon_e7;
        end
    end

    // per-axis quantizers at full length; shorter hashes use the top bits
    logic [LAT_N-1:0] lat_cell;
    logic [LON_N-1:0] lon_cell;

    gh_cell #(.BITS(LAT_N), .DIV(gh_pkg::LAT_DIV)) u_lat_cell (
        .aclk     (aclk),
        .adv      (adv),
        .coord    (lat_reg),
        .cell_num (lat_cell)
    );

    gh_cell #(.BITS(LON_N), .DIV(gh_pkg::LON_DIV)) u_lon_cell (
        .aclk     (aclk),
        .adv      (adv),
        .coord    (lon_reg),
        .cell_num (lon_cell)
    );

    // bit interleave, longitude first from the msb
    logic [TOTAL-1:0] word;

    always_comb begin
        word = '0;
        for (int i = 0; i < LON_N; i++) begin
            word[TOTAL-1-2*i] = lon_cell[LON_N-1-i];
        end
        for (int i = 0; i < LAT_N; i++) begin
            word[TOTAL-2-2*i] = lat_cell[LAT_N-1-i];
        end
    end

    // character serializer
    logic [TOTAL-1:0] shift_reg, shift_next;
    logic [3:0]       pos_reg, pos_next;
    logic [3:0]       len_reg, len_next;
    logic             load;

    assign last_cur = (pos_reg == (len_reg - 4'd1));
    assign load     = v4_reg && ser_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        shift_next   = shift_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        if (load) begin
            m_valid_next = (len_eff != 4'd0);
            shift_next   = word;
            pos_next     = 4'd0;
            len_next     = len_eff;
        end else if (m_valid_reg && m_ready) begin
            if (last_cur) begin
                m_valid_next = 1'b0;
            end else begin
                shift_next = shift_reg << 5;
                pos_next   = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        pos_reg   <= pos_next;
        len_reg   <= len_next;
    end

    // result outputs
    assign m_valid        = m_valid_reg;
    assign m_symbol_value = shift_reg[TOTAL-1 -: 5];
    assign m_symbol_char  = gh_pkg::sym_to_char(shift_reg[TOTAL-1 -: 5]);
    assign m_position     = pos_reg;
    assign m_last         = last_cur;

endmodule
